>>> sv/dllc_pkg.sv
// Package: opcodes, widths and types for the linked list cursor engine.
package dllc_pkg;
  localparam int unsigned PoolNodesDefault = 64;
  localparam int unsigned ValueWidth = 32;
  localparam int unsigned OpWidth = 5;

  localparam logic [OpWidth-1:0] OpClear = 5'd0;
  localparam logic [OpWidth-1:0] OpInsFirst = 5'd1;
  localparam logic [OpWidth-1:0] OpInsLast = 5'd2;
  localparam logic [OpWidth-1:0] OpToFirst = 5'd3;
  localparam logic [OpWidth-1:0] OpToLast = 5'd4;
  localparam logic [OpWidth-1:0] OpRdFirst = 5'd5;
  localparam logic [OpWidth-1:0] OpRdLast = 5'd6;
  localparam logic [OpWidth-1:0] OpDelFirst = 5'd7;
  localparam logic [OpWidth-1:0] OpDelLast = 5'd8;
  localparam logic [OpWidth-1:0] OpDelAfter = 5'd9;
  localparam logic [OpWidth-1:0] OpDelBefore = 5'd10;
  localparam logic [OpWidth-1:0] OpInsAfter = 5'd11;
  localparam logic [OpWidth-1:0] OpInsBefore = 5'd12;
  localparam logic [OpWidth-1:0] OpRdActive = 5'd13;
  localparam logic [OpWidth-1:0] OpWrActive = 5'd14;
  localparam logic [OpWidth-1:0] OpNext = 5'd15;
  localparam logic [OpWidth-1:0] OpPrev = 5'd16;

  typedef enum logic [8:0] {
    ST_IDLE = 9'b0_0000_0001,
    ST_DEC  = 9'b0_0000_0010,
    ST_CUR  = 9'b0_0000_0100,
    ST_TGT  = 9'b0_0000_1000,
    ST_SCAN = 9'b0_0001_0000,
    ST_NEW  = 9'b0_0010_0000,
    ST_PRD  = 9'b0_0100_0000,
    ST_NRD  = 9'b0_1000_0000,
    ST_OUT  = 9'b1_0000_0000
  } state_t;
endpackage

>>> sv/dllc_ram.sv
// Generic single-port-write, one-read RAM with registered read.
module dllc_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

>>> sv/dllc_free_map.sv
// In-use bitmap with lowest-free-index search.
module dllc_free_map #(
  parameter int unsigned PoolNodes = dllc_pkg::PoolNodesDefault
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         clr,
  input  logic                         set,
  input  logic                         free,
  input  logic [$clog2(PoolNodes)-1:0] idx,
  input  logic                         scan_start,
  output logic                         scan_done,
  output logic                         found,
  output logic [$clog2(PoolNodes)-1:0] free_idx
);
  localparam int unsigned IdxW = $clog2(PoolNodes);
  logic [PoolNodes-1:0] in_use;
  logic [IdxW:0] scan;
  logic scanning;

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      in_use <= '0;
    end else begin
      if (set) in_use[idx] <= 1'b1;
      if (free) in_use[idx] <= 1'b0;
    end
  end

  // one entry per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      scanning <= 1'b0;
      scan_done <= 1'b0;
      found <= 1'b0;
      scan <= '0;
    end else begin
      scan_done <= 1'b0;
      if (scan_start) begin
        scanning <= 1'b1;
        scan <= '0;
      end else if (scanning) begin
        if (scan == (IdxW+1)'(PoolNodes)) begin
          scanning <= 1'b0;
          scan_done <= 1'b1;
          found <= 1'b0;
        end else if (!in_use[scan[IdxW-1:0]]) begin
          scanning <= 1'b0;
          scan_done <= 1'b1;
          found <= 1'b1;
          free_idx <= scan[IdxW-1:0];
        end else begin
          scan <= scan + 1'b1;
        end
      end
    end
  end
endmodule

>>> sv/doubly_linked_list_cursor_engine_core.sv
// Doubly linked list cursor engine: sequencer over one node memory and an in-use map.
// Each op goes from accept through decode to the output register; ops other than clear,
// moves to first/last and no-ops also pass through node-memory states, and an insert first
// searches for the lowest free node, scanned one per cycle, and fails when the pool is full.
// Throughput: one item at a time; the next is taken the cycle after the result is
// registered, and a result stalled in the output register holds the next one back.
// Reset: synchronous; list empty, cursor null, in-use map cleared; node memory kept.
module doubly_linked_list_cursor_engine_core #(
  parameter int unsigned PoolNodes = dllc_pkg::PoolNodesDefault
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [dllc_pkg::OpWidth-1:0]          opcode,
  input  logic signed [dllc_pkg::ValueWidth-1:0] value,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [dllc_pkg::ValueWidth-1:0] read_value,
  output logic                                  error,
  output logic                                  cursor_active,
  output logic                                  list_empty
);
  localparam int unsigned IdxW = $clog2(PoolNodes);
  localparam int unsigned LinkW = IdxW + 1;
  localparam int unsigned VW = dllc_pkg::ValueWidth;
  localparam logic [LinkW-1:0] Nil = LinkW'(PoolNodes);
  localparam int unsigned NodeW = VW + 2 * LinkW;

  dllc_pkg::state_t state;
  logic [dllc_pkg::OpWidth-1:0] op;
  logic signed [VW-1:0] val;
  logic [LinkW-1:0] head, tail, cur;
  logic [LinkW-1:0] tgt, pl, nl, pnew, nnew, newk;
  logic [VW-1:0] rd;
  logic err;

  // node = {value, prev, next}
  logic we;
  logic [IdxW-1:0] waddr, raddr;
  logic [NodeW-1:0] wdata, rdata;
  logic [VW-1:0] r_val;
  logic [LinkW-1:0] r_prev, r_next;
  assign {r_val, r_prev, r_next} = rdata;

  dllc_ram #(.Width(NodeW), .Depth(PoolNodes)) u_ram (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  logic fm_clr, fm_set, fm_free, scan_start, scan_done, found;
  logic [IdxW-1:0] fm_idx, free_idx;
  dllc_free_map #(.PoolNodes(PoolNodes)) u_map (
    .clk, .rst, .clr(fm_clr), .set(fm_set), .free(fm_free), .idx(fm_idx),
    .scan_start, .scan_done, .found, .free_idx
  );

  function automatic logic is_node(input logic [LinkW-1:0] k);
    return k < Nil;
  endfunction

  logic out_free;
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != dllc_pkg::ST_IDLE);

  logic is_del;
  assign is_del = (op == dllc_pkg::OpDelFirst) || (op == dllc_pkg::OpDelLast) ||
                  (op == dllc_pkg::OpDelAfter) || (op == dllc_pkg::OpDelBefore);

  // neighbor of the cursor that a cursor delete removes
  logic [LinkW-1:0] cur_nbr;
  assign cur_nbr = (op == dllc_pkg::OpDelAfter) ? r_next : r_prev;

  // read address is issued in the state before the one that uses rdata (registered read)
  always_comb begin
    raddr = cur[IdxW-1:0];
    we = 1'b0;
    waddr = cur[IdxW-1:0];
    wdata = {val, r_prev, r_next};
    unique case (state)
      dllc_pkg::ST_DEC: begin
        if (op == dllc_pkg::OpRdFirst || op == dllc_pkg::OpDelFirst) begin
          raddr = head[IdxW-1:0];
        end else if (op == dllc_pkg::OpRdLast || op == dllc_pkg::OpDelLast) begin
          raddr = tail[IdxW-1:0];
        end
      end
      dllc_pkg::ST_CUR: begin
        raddr = cur_nbr[IdxW-1:0];
        we = (op == dllc_pkg::OpWrActive);
      end
      dllc_pkg::ST_TGT: raddr = r_prev[IdxW-1:0];
      dllc_pkg::ST_NEW: begin
        raddr = pl[IdxW-1:0];
        we = 1'b1;
        waddr = newk[IdxW-1:0];
        wdata = {val, pl, nl};
      end
      dllc_pkg::ST_PRD: begin
        raddr = nl[IdxW-1:0];
        we = is_node(pl);
        waddr = pl[IdxW-1:0];
        wdata = {r_val, r_prev, pnew};
      end
      dllc_pkg::ST_NRD: begin
        we = is_node(nl);
        waddr = nl[IdxW-1:0];
        wdata = {r_val, nnew, r_next};
      end
      default: ;
    endcase
  end

  assign fm_clr = (state == dllc_pkg::ST_DEC) && (op == dllc_pkg::OpClear);
  assign fm_set = (state == dllc_pkg::ST_NEW);
  assign fm_free = (state == dllc_pkg::ST_TGT) && is_del;
  assign fm_idx = fm_set ? newk[IdxW-1:0] : tgt[IdxW-1:0];
  assign scan_start = ((state == dllc_pkg::ST_DEC) &&
                       (op == dllc_pkg::OpInsFirst || op == dllc_pkg::OpInsLast)) ||
                      ((state == dllc_pkg::ST_CUR) &&
                       (op == dllc_pkg::OpInsAfter || op == dllc_pkg::OpInsBefore));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dllc_pkg::ST_IDLE;
      head <= Nil;
      tail <= Nil;
      cur <= Nil;
      out_valid <= 1'b0;
    end else begin
      if (state == dllc_pkg::ST_OUT && out_free) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      unique case (state)
        dllc_pkg::ST_IDLE: begin
          if (in_valid) begin
            op <= opcode;
            val <= value;
            rd <= '0;
            err <= 1'b0;
            state <= dllc_pkg::ST_DEC;
          end
        end
        dllc_pkg::ST_DEC: begin
          unique case (op) inside
            dllc_pkg::OpClear: begin
              head <= Nil; tail <= Nil; cur <= Nil;
              state <= dllc_pkg::ST_OUT;
            end
            dllc_pkg::OpToFirst: begin cur <= head; state <= dllc_pkg::ST_OUT; end
            dllc_pkg::OpToLast: begin cur <= tail; state <= dllc_pkg::ST_OUT; end
            dllc_pkg::OpRdFirst, dllc_pkg::OpDelFirst: begin
              tgt <= head;
              if (is_node(head)) state <= dllc_pkg::ST_TGT;
              else begin
                err <= (op == dllc_pkg::OpRdFirst);
                state <= dllc_pkg::ST_OUT;
              end
            end
            dllc_pkg::OpRdLast, dllc_pkg::OpDelLast: begin
              tgt <= tail;
              if (is_node(tail)) state <= dllc_pkg::ST_TGT;
              else begin
                err <= (op == dllc_pkg::OpRdLast);
                state <= dllc_pkg::ST_OUT;
              end
            end
            dllc_pkg::OpInsFirst: begin
              pl <= Nil; nl <= head; state <= dllc_pkg::ST_SCAN;
            end
            dllc_pkg::OpInsLast: begin
              pl <= tail; nl <= Nil; state <= dllc_pkg::ST_SCAN;
            end
            dllc_pkg::OpDelAfter, dllc_pkg::OpDelBefore, dllc_pkg::OpInsAfter,
            dllc_pkg::OpInsBefore, dllc_pkg::OpRdActive, dllc_pkg::OpWrActive,
            dllc_pkg::OpNext, dllc_pkg::OpPrev: begin
              if (is_node(cur)) state <= dllc_pkg::ST_CUR;
              else begin
                err <= (op == dllc_pkg::OpRdActive);
                state <= dllc_pkg::ST_OUT;
              end
            end
            default: state <= dllc_pkg::ST_OUT;
          endcase
        end
        dllc_pkg::ST_CUR: begin
          // rdata holds the cursor node
          unique case (op) inside
            dllc_pkg::OpRdActive: begin rd <= r_val; state <= dllc_pkg::ST_OUT; end
            dllc_pkg::OpNext: begin cur <= r_next; state <= dllc_pkg::ST_OUT; end
            dllc_pkg::OpPrev: begin cur <= r_prev; state <= dllc_pkg::ST_OUT; end
            dllc_pkg::OpInsAfter: begin
              pl <= cur; nl <= r_next; state <= dllc_pkg::ST_SCAN;
            end
            dllc_pkg::OpInsBefore: begin
              pl <= r_prev; nl <= cur; state <= dllc_pkg::ST_SCAN;
            end
            dllc_pkg::OpDelAfter, dllc_pkg::OpDelBefore: begin
              tgt <= cur_nbr;
              state <= is_node(cur_nbr) ? dllc_pkg::ST_TGT : dllc_pkg::ST_OUT;
            end
            default: state <= dllc_pkg::ST_OUT;
          endcase
        end
        dllc_pkg::ST_TGT: begin
          // rdata holds the target node
          if (is_del) begin
            pl <= r_prev;
            nl <= r_next;
            pnew <= r_next;
            nnew <= r_prev;
            if (!is_node(r_prev)) head <= r_next;
            if (!is_node(r_next)) tail <= r_prev;
            if (cur == tgt) cur <= Nil;
            state <= dllc_pkg::ST_PRD;
          end else begin
            rd <= r_val;
            state <= dllc_pkg::ST_OUT;
          end
        end
        dllc_pkg::ST_SCAN: begin
          if (scan_done) begin
            if (found) begin
              newk <= {1'b0, free_idx};
              pnew <= {1'b0, free_idx};
              nnew <= {1'b0, free_idx};
              state <= dllc_pkg::ST_NEW;
            end else begin
              err <= 1'b1;
              state <= dllc_pkg::ST_OUT;
            end
          end
        end
        dllc_pkg::ST_NEW: begin
          if (!is_node(pl)) head <= newk;
          if (!is_node(nl)) tail <= newk;
          state <= dllc_pkg::ST_PRD;
        end
        dllc_pkg::ST_PRD: state <= dllc_pkg::ST_NRD;
        dllc_pkg::ST_NRD: state <= dllc_pkg::ST_OUT;
        dllc_pkg::ST_OUT: begin
          if (out_free) begin
            read_value <= rd;
            error <= err;
            cursor_active <= is_node(cur);
            list_empty <= !is_node(head);
            state <= dllc_pkg::ST_IDLE;
          end
        end
        default: state <= dllc_pkg::ST_IDLE;
      endcase
    end
  end
endmodule

>>> sv/dllc_checker.sv
// Port-level checker for the linked list cursor engine, bound to the top.
module dllc_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic signed [31:0] read_value,
  input logic error,
  input logic cursor_active,
  input logic list_empty
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(read_value))
    else $error("result dropped under stall");
  a_empty_no_cursor: assert property (@(posedge clk) disable iff (rst)
    out_valid && list_empty |-> !cursor_active)
    else $error("cursor active on empty list");
  a_err_no_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && error |-> read_value == 32'sd0)
    else $error("failed op returned data");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second beat taken while busy");
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result right after reset");
endmodule

bind doubly_linked_list_cursor_engine_core dllc_checker u_chk (
  .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall,
  .read_value, .error, .cursor_active, .list_empty
);

>>> tb/sv/testbench.sv
// Testbench for the linked list cursor engine: directed table plus random ops.
`timescale 1ns / 100ps

module testbench;
  localparam int Pool = dllc_pkg::PoolNodesDefault;
  localparam int Nil = Pool;
  localparam int NumRandom = 500;

  typedef struct packed {
    logic signed [31:0] rd;
    logic               err;
    logic               act;
    logic               empty;
  } status_t;

  typedef struct packed {
    logic [4:0]         op;
    logic signed [31:0] val;
    logic               typed;
    status_t            res;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [4:0] opcode = '0;
  logic signed [31:0] value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] read_value;
  logic error;
  logic cursor_active;
  logic list_empty;

  doubly_linked_list_cursor_engine_core u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .value(value),
    .out_valid(out_valid), .out_stall(out_stall),
    .read_value(read_value), .error(error),
    .cursor_active(cursor_active), .list_empty(list_empty)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // list shadow
  logic signed [31:0] lst_val [Pool];
  int lst_prev [Pool];
  int lst_next [Pool];
  bit lst_used [Pool];
  int lst_head, lst_tail, lst_cur, lst_count;
  status_t status_q[$];
  int fails = 0;
  int sink_wait = 0;
  bit stim_done = 1'b0;

  function automatic void list_clear();
    for (int k = 0; k < Pool; k++) begin
      lst_used[k] = 1'b0;
      lst_prev[k] = Nil;
      lst_next[k] = Nil;
    end
    lst_head = Nil;
    lst_tail = Nil;
    lst_cur = Nil;
    lst_count = 0;
  endfunction

  function automatic void list_unlink(int k);
    int p, n;
    if (k >= Nil) return;
    p = lst_prev[k];
    n = lst_next[k];
    if (p < Nil) lst_next[p] = n; else lst_head = n;
    if (n < Nil) lst_prev[n] = p; else lst_tail = p;
    if (lst_cur == k) lst_cur = Nil;
    lst_used[k] = 1'b0;
    lst_count--;
  endfunction

  function automatic bit list_link(int p, int n, logic signed [31:0] v);
    int k;
    k = Nil;
    for (int i = 0; i < Pool; i++) begin
      if (!lst_used[i] && k == Nil) k = i;
    end
    if (k == Nil) return 1'b0;
    lst_used[k] = 1'b1;
    lst_val[k] = v;
    lst_prev[k] = p;
    lst_next[k] = n;
    if (p < Nil) lst_next[p] = k; else lst_head = k;
    if (n < Nil) lst_prev[n] = k; else lst_tail = k;
    lst_count++;
    return 1'b1;
  endfunction

  function automatic status_t list_apply(logic [4:0] op, logic signed [31:0] v);
    status_t r;
    bit act;
    r = '0;
    act = lst_cur < Nil;
    case (op)
      dllc_pkg::OpClear: list_clear();
      dllc_pkg::OpInsFirst: r.err = !list_link(Nil, lst_head, v);
      dllc_pkg::OpInsLast: r.err = !list_link(lst_tail, Nil, v);
      dllc_pkg::OpToFirst: lst_cur = lst_head;
      dllc_pkg::OpToLast: lst_cur = lst_tail;
      dllc_pkg::OpRdFirst: if (lst_head < Nil) r.rd = lst_val[lst_head]; else r.err = 1'b1;
      dllc_pkg::OpRdLast: if (lst_tail < Nil) r.rd = lst_val[lst_tail]; else r.err = 1'b1;
      dllc_pkg::OpDelFirst: list_unlink(lst_head);
      dllc_pkg::OpDelLast: list_unlink(lst_tail);
      dllc_pkg::OpDelAfter: if (act) list_unlink(lst_next[lst_cur]);
      dllc_pkg::OpDelBefore: if (act) list_unlink(lst_prev[lst_cur]);
      dllc_pkg::OpInsAfter: if (act) r.err = !list_link(lst_cur, lst_next[lst_cur], v);
      dllc_pkg::OpInsBefore: if (act) r.err = !list_link(lst_prev[lst_cur], lst_cur, v);
      dllc_pkg::OpRdActive: if (act) r.rd = lst_val[lst_cur]; else r.err = 1'b1;
      dllc_pkg::OpWrActive: if (act) lst_val[lst_cur] = v;
      dllc_pkg::OpNext: if (act) lst_cur = lst_next[lst_cur];
      dllc_pkg::OpPrev: if (act) lst_cur = lst_prev[lst_cur];
      default: ;
    endcase
    r.act = lst_cur < Nil;
    r.empty = lst_head >= Nil;
    return r;
  endfunction

  // called and left at a falling edge; valid stays high when no gap follows
  task automatic send_op(logic [4:0] op, logic signed [31:0] v, bit typed, status_t res);
    status_t pred;
    int gap;
    gap = $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = list_apply(op, v);
    if (typed && pred !== res) begin
      $error("table row op %0d: typed result %h differs from predictor %h", op, res, pred);
      fails++;
    end
    status_q.push_back(pred);
    @(negedge clk);
  endtask

  // sink: after each beat it draws how many cycles to stall
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      sink_wait = 0;
    end else if (sink_wait > 0) begin
      out_stall <= 1'b1;
      sink_wait--;
    end else begin
      out_stall <= 1'b0;
      if (out_valid) sink_wait = $urandom_range(0, 13);
    end
  end

  always @(posedge clk) begin
    status_t e;
    if (!rst && out_valid && !out_stall) begin
      if (status_q.size() == 0) begin
        $error("result beat with no expectation");
        fails++;
      end else begin
        e = status_q.pop_front();
        if (read_value !== e.rd) begin
          $error("read_value: expected %0d actual %0d", e.rd, read_value); fails++;
        end
        if (error !== e.err) begin
          $error("error: expected %0b actual %0b", e.err, error); fails++;
        end
        if (cursor_active !== e.act) begin
          $error("cursor_active: expected %0b actual %0b", e.act, cursor_active); fails++;
        end
        if (list_empty !== e.empty) begin
          $error("list_empty: expected %0b actual %0b", e.empty, list_empty); fails++;
        end
      end
    end
  end

  function automatic row_t mk(logic [4:0] op, logic signed [31:0] v, bit t,
                              logic signed [31:0] rd, bit err, bit act, bit emp);
    row_t r;
    r.op = op; r.val = v; r.typed = t;
    r.res.rd = rd; r.res.err = err; r.res.act = act; r.res.empty = emp;
    return r;
  endfunction

  function automatic logic signed [31:0] rand_val();
    case ($urandom_range(0, 4))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return -1;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    row_t dir[$];
    logic [4:0] op;
    int mode;
    list_clear();
    // empty list reads and no-ops
    dir.push_back(mk(dllc_pkg::OpRdFirst, 0, 1, 0, 1, 0, 1));
    dir.push_back(mk(dllc_pkg::OpRdLast, 0, 1, 0, 1, 0, 1));
    dir.push_back(mk(dllc_pkg::OpRdActive, 0, 1, 0, 1, 0, 1));
    dir.push_back(mk(dllc_pkg::OpToFirst, 0, 1, 0, 0, 0, 1));
    dir.push_back(mk(dllc_pkg::OpDelFirst, 0, 1, 0, 0, 0, 1));
    dir.push_back(mk(dllc_pkg::OpInsAfter, 5, 1, 0, 0, 0, 1));
    dir.push_back(mk(dllc_pkg::OpNext, 0, 1, 0, 0, 0, 1));
    dir.push_back(mk(dllc_pkg::OpInsFirst, 32'sh7fff_ffff, 1, 0, 0, 0, 0));
    dir.push_back(mk(dllc_pkg::OpInsLast, 32'sh8000_0000, 1, 0, 0, 0, 0));
    dir.push_back(mk(dllc_pkg::OpRdFirst, 0, 1, 32'sh7fff_ffff, 0, 0, 0));
    dir.push_back(mk(dllc_pkg::OpRdLast, 0, 1, 32'sh8000_0000, 0, 0, 0));
    dir.push_back(mk(dllc_pkg::OpToFirst, 0, 1, 0, 0, 1, 0));
    dir.push_back(mk(dllc_pkg::OpInsAfter, -1, 0, 0, 0, 0, 0));
    dir.push_back(mk(dllc_pkg::OpInsBefore, 7, 0, 0, 0, 0, 0));
    dir.push_back(mk(dllc_pkg::OpWrActive, 32'sh5555_aaaa, 0, 0, 0, 0, 0));
    dir.push_back(mk(dllc_pkg::OpRdActive, 0, 1, 32'sh5555_aaaa, 0, 1, 0));
    dir.push_back(mk(dllc_pkg::OpPrev, 0, 0, 0, 0, 0, 0));
    dir.push_back(mk(dllc_pkg::OpPrev, 0, 0, 0, 0, 0, 0));
    dir.push_back(mk(dllc_pkg::OpToLast, 0, 0, 0, 0, 0, 0));
    dir.push_back(mk(dllc_pkg::OpDelBefore, 0, 0, 0, 0, 0, 0));
    dir.push_back(mk(dllc_pkg::OpDelAfter, 0, 0, 0, 0, 0, 0));
    dir.push_back(mk(dllc_pkg::OpDelLast, 0, 1, 0, 0, 0, 0));
    dir.push_back(mk(5'd31, 0, 0, 0, 0, 0, 0));
    dir.push_back(mk(5'd17, 0, 0, 0, 0, 0, 0));
    dir.push_back(mk(dllc_pkg::OpClear, 0, 1, 0, 0, 0, 1));
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (dir[i]) send_op(dir[i].op, dir[i].val, dir[i].typed, dir[i].res);
    // fill the pool to its limit, overflow on both ends and at the cursor
    for (int i = 0; i < Pool + 2; i++) send_op(dllc_pkg::OpInsLast, rand_val(), 0, '0);
    send_op(dllc_pkg::OpInsFirst, 1, 0, '0);
    send_op(dllc_pkg::OpToFirst, 0, 0, '0);
    send_op(dllc_pkg::OpInsAfter, 2, 0, '0);
    send_op(dllc_pkg::OpInsBefore, 3, 0, '0);
    // drain before going on
    in_valid <= 1'b0;
    do @(negedge clk); while (status_q.size() != 0);
    send_op(dllc_pkg::OpClear, 0, 0, '0);
    for (int n = 0; n < NumRandom; n++) begin
      mode = $urandom_range(0, 99);
      if (mode < 3) op = dllc_pkg::OpClear;
      else if (mode < 5) op = 5'($urandom_range(17, 31));
      else if (lst_count < 6 && mode < 40)
        op = ($urandom_range(0, 1)) ? dllc_pkg::OpInsLast : dllc_pkg::OpInsFirst;
      else if (lst_cur == Nil && mode < 55)
        op = ($urandom_range(0, 1)) ? dllc_pkg::OpToFirst : dllc_pkg::OpToLast;
      else op = 5'($urandom_range(1, 16));
      if (n == 300) begin
        while (lst_count < Pool) send_op(dllc_pkg::OpInsLast, rand_val(), 0, '0);
      end
      send_op(op, rand_val(), 0, '0);
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    while (status_q.size() != 0) @(negedge clk);
    repeat (Pool + 20) @(posedge clk);
    if (fails == 0 && status_q.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule
